// ===== rtl/core/dmtbh_pkg.sv =====
// ----------------------------------------------------------------------------
// Davies-Meyer TEA byte hash: shared definitions
// Constants, job codes and the job record passed from the front end to the
// round engine.
// ----------------------------------------------------------------------------
package dmtbh_pkg;

    localparam int LEN_BITS     = 16;
    localparam int BLOCK_BYTES  = 16;
    localparam int BLOCK_WORDS  = 4;
    localparam int FILL_W       = $clog2(BLOCK_BYTES);

    localparam int BLOCK_ROUNDS = 6;
    localparam int FINAL_ROUNDS = 10;
    localparam int ROUND_W      = $clog2(FINAL_ROUNDS + 1);

    localparam logic [31:0] TEA_DELTA = 32'h9E37_79B9;
    localparam logic [31:0] INIT_A    = 32'h9464_a485;
    localparam logic [31:0] INIT_B    = 32'h542e_1a94;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Job kinds: a full block, a final block, or a full block followed by
    // a final block made of pad words only.
    localparam logic [1:0] KIND_BLOCK       = 2'd0;
    localparam logic [1:0] KIND_FINAL       = 2'd1;
    localparam logic [1:0] KIND_BLOCK_FINAL = 2'd2;

    typedef struct packed {
        logic [1:0]                        kind;
        logic [31:0]                       pad;
        logic [BLOCK_WORDS-1:0][31:0]      key;
    } job_t;

endpackage

// ===== rtl/core/dmtbh_front.sv =====
// ----------------------------------------------------------------------------
// Davies-Meyer TEA byte hash: front end
// Gathers message bytes into a 16-byte block, counts the message length and
// builds round jobs with their key words for the round engine.
// ----------------------------------------------------------------------------
module dmtbh_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    input  logic              q_full,
    output logic              job_push,
    output dmtbh_pkg::job_t   job
);
    import dmtbh_pkg::*;

    logic [7:0]          bytes_reg [BLOCK_BYTES];
    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   fill_next;
    logic [LEN_BITS-1:0] len_reg;
    logic [LEN_BITS-1:0] len_next;
    logic [LEN_BITS-1:0] len_inc;
    logic                accept;
    logic                block_done;
    logic [7:0]          cur [BLOCK_BYTES];
    logic [31:0]         blk_word [BLOCK_WORDS];
    logic [31:0]         len_word;
    logic [31:0]         pad_half;
    logic [31:0]         pad;
    logic [FILL_W-1:0]   fill_inc;
    logic [1:0]          whole;
    logic [1:0]          tail;

    assign full       = q_full;
    assign accept     = push && !q_full;
    assign block_done = (fill_reg == FILL_W'(BLOCK_BYTES - 1));
    assign len_inc    = len_reg + LEN_BITS'(1);
    assign len_word   = 32'(len_inc);
    assign pad_half   = len_word | (len_word << 8);
    assign pad        = pad_half | (pad_half << 16);
    assign fill_inc   = fill_reg + FILL_W'(1);
    assign whole      = fill_inc[3:2];
    assign tail       = fill_inc[1:0];

    always_comb
    begin
        for (int i = 0; i < BLOCK_BYTES; i++)
        begin
            cur[i] = (fill_reg == FILL_W'(i)) ? data_byte : bytes_reg[i];
        end
        for (int j = 0; j < BLOCK_WORDS; j++)
        begin
            blk_word[j] = {cur[4*j+3], cur[4*j+2], cur[4*j+1], cur[4*j]};
        end
    end

    always_comb
    begin
        job_push = accept && (block_done || last_byte);
        job.pad  = pad;
        if (block_done)
        begin
            job.kind = last_byte ? KIND_BLOCK_FINAL : KIND_BLOCK;
            for (int j = 0; j < BLOCK_WORDS; j++)
            begin
                job.key[j] = blk_word[j];
            end
        end
        else
        begin
            job.kind = KIND_FINAL;
            for (int j = 0; j < BLOCK_WORDS; j++)
            begin
                if (2'(j) < whole)
                begin
                    job.key[j] = blk_word[j];
                end
                else if (2'(j) == whole)
                begin
                    unique case (tail)
                        2'd0: job.key[j] = pad;
                        2'd1: job.key[j] = {pad[23:0], cur[4*j]};
                        2'd2: job.key[j] = {pad[15:0], cur[4*j], cur[4*j+1]};
                        2'd3: job.key[j] = {pad[7:0], cur[4*j], cur[4*j+1],
                                            cur[4*j+2]};
                    endcase
                end
                else
                begin
                    job.key[j] = pad;
                end
            end
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        len_next  = len_reg;
        if (accept)
        begin
            fill_next = (block_done || last_byte) ? '0 : fill_inc;
            len_next  = last_byte ? '0 : len_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            len_reg  <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            len_reg  <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bytes_reg[fill_reg] <= data_byte;
        end
    end

endmodule

// ===== rtl/core/dmtbh_job_queue.sv =====
// ----------------------------------------------------------------------------
// Davies-Meyer TEA byte hash: job queue
// Short first-in first-out queue of round jobs between the front end and the
// round engine.
// ----------------------------------------------------------------------------
module dmtbh_job_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  dmtbh_pkg::job_t   wr_job,
    output logic              q_full,
    input  logic              rd_en,
    output dmtbh_pkg::job_t   rd_job,
    output logic              q_empty
);
    import dmtbh_pkg::*;

    job_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg;
    logic [QUEUE_CW-1:0] count_next;
    logic                do_wr;
    logic                do_rd;

    assign q_full  = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_job  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QUEUE_AW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QUEUE_AW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + QUEUE_CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - QUEUE_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

// ===== rtl/core/dmtbh_back.sv =====
// ----------------------------------------------------------------------------
// Davies-Meyer TEA byte hash: round engine
// Runs TEA-style rounds, one half-round per cycle, feeds the result forward
// into the chaining words and holds the finished hash for the receiver.
// ----------------------------------------------------------------------------
module dmtbh_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_empty,
    input  dmtbh_pkg::job_t   job,
    output logic              job_take,
    output logic              empty,
    input  logic              pop,
    output logic [31:0]       hash_value
);
    import dmtbh_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_XHALF = 2'd1;
    localparam logic [1:0] ST_YHALF = 2'd2;
    localparam logic [1:0] ST_FEED  = 2'd3;

    logic [1:0]                   state_reg;
    logic [1:0]                   state_next;
    logic [1:0]                   kind_reg;
    logic [1:0]                   kind_next;
    logic [ROUND_W-1:0]           round_reg;
    logic [ROUND_W-1:0]           round_next;
    logic [31:0]                  chain_a_reg;
    logic [31:0]                  chain_a_next;
    logic [31:0]                  chain_b_reg;
    logic [31:0]                  chain_b_next;
    logic [31:0]                  x_reg;
    logic [31:0]                  x_next;
    logic [31:0]                  y_reg;
    logic [31:0]                  y_next;
    logic [31:0]                  s_reg;
    logic [31:0]                  s_next;
    logic [BLOCK_WORDS-1:0][31:0] key_reg;
    logic [BLOCK_WORDS-1:0][31:0] key_next;
    logic [31:0]                  pad_reg;
    logic [31:0]                  pad_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [31:0]                  hash_reg;
    logic [31:0]                  hash_next;
    logic [31:0]                  fx;
    logic [31:0]                  fy;
    logic [31:0]                  sum_a;
    logic [31:0]                  sum_b;
    logic                         out_free;

    assign fx    = ((y_reg << 4) + key_reg[0]) ^ (y_reg + s_reg)
                 ^ ((y_reg >> 5) + key_reg[1]);
    assign fy    = ((x_reg << 4) + key_reg[2]) ^ (x_reg + s_reg)
                 ^ ((x_reg >> 5) + key_reg[3]);
    assign sum_a = chain_a_reg + x_reg;
    assign sum_b = chain_b_reg + y_reg;

    assign out_free   = !out_valid_reg || pop;
    assign empty      = !out_valid_reg;
    assign hash_value = hash_reg;

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        round_next     = round_reg;
        chain_a_next   = chain_a_reg;
        chain_b_next   = chain_b_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        s_next         = s_reg;
        key_next       = key_reg;
        pad_next       = pad_reg;
        hash_next      = hash_reg;
        out_valid_next = out_valid_reg && !pop;
        job_take       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!job_empty)
                begin
                    job_take   = 1'b1;
                    key_next   = job.key;
                    pad_next   = job.pad;
                    kind_next  = job.kind;
                    x_next     = chain_a_reg;
                    y_next     = chain_b_reg;
                    s_next     = TEA_DELTA;
                    round_next = (job.kind == KIND_FINAL) ? ROUND_W'(FINAL_ROUNDS)
                                                          : ROUND_W'(BLOCK_ROUNDS);
                    state_next = ST_XHALF;
                end
            end
            ST_XHALF:
            begin
                x_next     = x_reg + fx;
                state_next = ST_YHALF;
            end
            ST_YHALF:
            begin
                y_next = y_reg + fy;
                s_next = s_reg + TEA_DELTA;
                if (round_reg == ROUND_W'(1))
                begin
                    state_next = ST_FEED;
                end
                else
                begin
                    round_next = round_reg - ROUND_W'(1);
                    state_next = ST_XHALF;
                end
            end
            ST_FEED:
            begin
                unique case (kind_reg)
                    KIND_BLOCK:
                    begin
                        chain_a_next = sum_a;
                        chain_b_next = sum_b;
                        state_next   = ST_IDLE;
                    end
                    KIND_BLOCK_FINAL:
                    begin
                        chain_a_next = sum_a;
                        chain_b_next = sum_b;
                        x_next       = sum_a;
                        y_next       = sum_b;
                        s_next       = TEA_DELTA;
                        key_next     = {BLOCK_WORDS{pad_reg}};
                        kind_next    = KIND_FINAL;
                        round_next   = ROUND_W'(FINAL_ROUNDS);
                        state_next   = ST_XHALF;
                    end
                    KIND_FINAL:
                    begin
                        if (out_free)
                        begin
                            hash_next      = sum_a ^ sum_b;
                            out_valid_next = 1'b1;
                            chain_a_next   = INIT_A;
                            chain_b_next   = INIT_B;
                            state_next     = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= KIND_BLOCK;
            round_reg     <= '0;
            chain_a_reg   <= INIT_A;
            chain_b_reg   <= INIT_B;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            round_reg     <= round_next;
            chain_a_reg   <= chain_a_next;
            chain_b_reg   <= chain_b_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        s_reg    <= s_next;
        key_reg  <= key_next;
        pad_reg  <= pad_next;
        hash_reg <= hash_next;
    end

endmodule

// ===== rtl/core/davies_meyer_tea_byte_hash.sv =====
// ----------------------------------------------------------------------------
// Davies-Meyer TEA byte hash: top level
// Byte-serial 32-bit hash with a TEA-style round in Davies-Meyer feed-forward.
// ----------------------------------------------------------------------------
// The input side is a queue: a byte and its last marker are taken at a clock
// edge with push high and full low, so one byte can be accepted every cycle.
// Each sixteenth byte of a message, and the final byte, becomes a round request
// in a two-entry queue ahead of the round engine; full rises only when that
// queue is full.
// The round engine does one half-round per cycle. A full block takes a request
// fetch, 12 half-rounds and a feed-forward step and ends before the next block
// of bytes is in, so a long message streams at one byte per cycle while full
// stays low. The final block runs FINAL_ROUNDS rounds; when the final byte also
// completes a block, a final block of pad words follows that block directly.
// The result side is a queue too: empty low presents the hash, and it is
// taken at an edge with pop high. While the receiver stalls, one hash waits
// in the output register and the engine holds its next final result.
// Reset clears the fill and length counters and the queues and reloads the
// initial chaining words; no hash is pending afterwards.
// ----------------------------------------------------------------------------
module davies_meyer_tea_byte_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] hash_value
);
    import dmtbh_pkg::*;

    logic job_push;
    job_t job_in;
    logic q_full;
    logic q_empty;
    job_t job_out;
    logic job_take;

    dmtbh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .q_full    (q_full),
        .job_push  (job_push),
        .job       (job_in)
    );

    dmtbh_job_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_job  (job_in),
        .q_full  (q_full),
        .rd_en   (job_take),
        .rd_job  (job_out),
        .q_empty (q_empty)
    );

    dmtbh_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_empty  (q_empty),
        .job        (job_out),
        .job_take   (job_take),
        .empty      (empty),
        .pop        (pop),
        .hash_value (hash_value)
    );

    // The front end never offers a request that the queue cannot hold.
    assert property (@(posedge clk) disable iff (!rst_n) job_push |-> !q_full)
        else $error("round request offered to a full queue");

    // The engine only takes a request that is present.
    assert property (@(posedge clk) disable iff (!rst_n) job_take |-> !q_empty)
        else $error("round request taken from an empty queue");

    // A final byte always yields a request in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && last_byte) |-> job_push)
        else $error("final byte produced no round request");

endmodule
